@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and defaults shared by the sorted priority event queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;
  localparam logic [1:0] KIND_APPEND = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
    logic [15:0] tstamp;
  } slot_t;

  typedef struct packed {
    logic  ins;
    logic  app;
    logic  pop;
    logic  find;
    slot_t slot;
  } cell_req_t;

  typedef struct packed {
    logic seen;
    logic found;
  } chain_t;

endpackage

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue: holds an event and shifts with its neighbours.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  logic              occ,
  input  spq_pkg::cell_req_t req,
  input  spq_pkg::slot_t     left,
  input  spq_pkg::slot_t     right,
  input  spq_pkg::chain_t    chain_in,
  output spq_pkg::chain_t    chain_out,
  output spq_pkg::slot_t     data
);
  import spq_pkg::*;

  logic hit;

  assign hit = (req.ins && (!occ || (req.slot.pri > data.pri))) || (req.app && !occ);

  assign chain_out.seen  = chain_in.seen | hit;
  assign chain_out.found = chain_in.found | (req.find && occ && (data.id == req.slot.id));

  always_ff @(posedge clk) begin
    if (chain_in.seen) begin
      data <= left;
    end else if (hit) begin
      data <= req.slot;
    end else if (req.pop) begin
      data <= right;
    end
  end

endmodule

@@ rtl/sorted_priority_event_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_event_queue_core
// Bounded event queue kept in service order in a row of shifting slots.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle unless stalled, and its result item
// appears on the output register in the cycle after acceptance. Each slot
// compares itself with the request in parallel; the insert position travels
// as a ripple flag along the slot row, which sets the cycle time for large
// DEPTH. Occupancy after each request is reported with every result.
module sorted_priority_event_queue_core #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic [15:0]                    event_id,
  input  logic [7:0]                     event_priority,
  input  logic [15:0]                    event_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [15:0]                    out_id,
  output logic [7:0]                     out_priority,
  output logic [15:0]                    out_time,
  output logic [$clog2(DEPTH+1)-1:0]     occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          acc;
  logic          full;
  logic          empty;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  cell_req_t     req;
  slot_t         cell_data [DEPTH];
  chain_t        chain [DEPTH];
  logic [DEPTH-1:0] occ;

  logic [1:0]  status_next;
  logic [15:0] out_id_next;
  logic [7:0]  out_priority_next;
  logic [15:0] out_time_next;

  assign in_ready  = !out_valid || out_ready;
  assign acc       = in_valid && in_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign occupancy = count;

  assign req.ins         = acc && (kind == KIND_INSERT) && !full;
  assign req.app         = acc && (kind == KIND_APPEND) && !full;
  assign req.pop         = acc && (kind == KIND_POP) && !empty;
  assign req.find        = acc && (kind == KIND_FIND);
  assign req.slot.id     = event_id;
  assign req.slot.pri    = event_priority;
  assign req.slot.tstamp = event_time;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    slot_t  left;
    slot_t  right;
    chain_t cin;

    assign occ[g] = (CW'(g) < count);

    if (g == 0) begin : g_head
      assign left = req.slot;
      assign cin  = '0;
    end else begin : g_body
      assign left = cell_data[g-1];
      assign cin  = chain[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right = cell_data[g];
    end else begin : g_inner
      assign right = cell_data[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .occ       (occ[g]),
      .req       (req),
      .left      (left),
      .right     (right),
      .chain_in  (cin),
      .chain_out (chain[g]),
      .data      (cell_data[g])
    );
  end

  always_comb begin
    count_next        = count;
    status_next       = ST_OK;
    out_id_next       = '0;
    out_priority_next = '0;
    out_time_next     = '0;
    case (kind)
      KIND_INSERT, KIND_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next        = count - CW'(1);
          out_id_next       = cell_data[0].id;
          out_priority_next = cell_data[0].pri;
          out_time_next     = cell_data[0].tstamp;
        end
      end
      KIND_FIND: begin
        if (chain[DEPTH-1].found) begin
          out_id_next = event_id;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status       <= status_next;
      out_id       <= out_id_next;
      out_priority <= out_priority_next;
      out_time     <= out_time_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (acc && (kind == KIND_POP) && !empty) |=> (count == $past(count) - CW'(1)))
    else $error("pop did not shrink the queue");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (acc && ((kind == KIND_INSERT) || (kind == KIND_APPEND)) && full)
      |=> (out_valid && (status == ST_FULL) && (count == $past(count))))
    else $error("full queue accepted an event");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (acc && (kind == KIND_POP) && empty) |=> (out_valid && (status == ST_EMPTY)))
    else $error("pop on empty queue not flagged");

endmodule

@@ sim/sorted_priority_event_queue_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_event_queue_checker
// Watches both channels of the event queue, keeps its own ordered copy of
// the stored events, works out the reply owed for every accepted request and
// compares each reply field by field, in order, against the oldest one owed.
// ----------------------------------------------------------------------------
module sorted_priority_event_queue_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic [15:0]                event_id,
  input  logic [7:0]                 event_priority,
  input  logic [15:0]                event_time,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 status,
  input  logic [15:0]                out_id,
  input  logic [7:0]                 out_priority,
  input  logic [15:0]                out_time,
  input  logic [$clog2(DEPTH+1)-1:0] occupancy,
  output int                         fail_count,
  output int                         owed_count,
  output int                         replies_checked,
  output int                         full_refusals,
  output int                         empty_refusals
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [1:0]                 st;
    logic [15:0]                id;
    logic [7:0]                 pri;
    logic [15:0]                tstamp;
    logic [$clog2(DEPTH+1)-1:0] occ;
  } reply_t;

  slot_t       ev_slot [DEPTH];
  int unsigned ev_count;
  reply_t      owed_replies [$];

  initial begin
    fail_count      = 0;
    owed_count      = 0;
    replies_checked = 0;
    full_refusals   = 0;
    empty_refusals  = 0;
    ev_count        = 0;
  end

  task automatic apply_request(input logic [1:0] k, input logic [15:0] id,
                               input logic [7:0] pri, input logic [15:0] ts);
    reply_t      r;
    int unsigned pos;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    case (k)
      KIND_INSERT, KIND_APPEND: begin
        if (ev_count >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          pos = ev_count;
          if (k == KIND_INSERT) begin
            for (int i = 0; i < ev_count; i++) begin
              if (pri > ev_slot[i].pri) begin
                pos = i;
                break;
              end
            end
          end
          for (int i = ev_count; i > pos; i--) ev_slot[i] = ev_slot[i-1];
          ev_slot[pos] = '{id: id, pri: pri, tstamp: ts};
          ev_count++;
        end
      end
      KIND_POP: begin
        if (ev_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.id     = ev_slot[0].id;
          r.pri    = ev_slot[0].pri;
          r.tstamp = ev_slot[0].tstamp;
          for (int i = 1; i < ev_count; i++) ev_slot[i-1] = ev_slot[i];
          ev_count--;
        end
      end
      default: begin
        for (int i = 0; i < ev_count; i++) begin
          if (ev_slot[i].id == id) hit = 1'b1;
        end
        if (hit) r.id = id;
        else r.st = ST_NOT_FOUND;
      end
    endcase
    r.occ = CW'(ev_count);
    owed_replies.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (owed_replies.size() == 0) begin
      $display("%0t: reply with none owed, status %h id %h pri %h time %h occ %0d",
               $time, status, out_id, out_priority, out_time, occupancy);
      fail_count++;
    end else begin
      want = owed_replies.pop_front();
      compare_field("status", 16'(want.st), 16'(status));
      compare_field("out_id", want.id, out_id);
      compare_field("out_priority", 16'(want.pri), 16'(out_priority));
      compare_field("out_time", want.tstamp, out_time);
      compare_field("occupancy", 16'(want.occ), 16'(occupancy));
      replies_checked++;
      if (want.st == ST_FULL) full_refusals++;
      if (want.st == ST_EMPTY) empty_refusals++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ev_count = 0;
      owed_replies.delete();
    end else begin
      if (in_valid && in_ready) apply_request(kind, event_id, event_priority, event_time);
      if (out_valid && out_ready) check_reply();
    end
    owed_count = owed_replies.size();
  end

endmodule

@@ sim/sorted_priority_event_queue_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_event_queue_core_tb
// Drives requests into the event queue with random gaps and output stalls:
// a directed opening over the corner cases, then random segments biased to
// fill, drain or mix. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module sorted_priority_event_queue_core_tb;
  import spq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int RAND_ITEMS  = 650;
  localparam int CYCLE_LIMIT = 200000;

  logic                       clk            = 1'b0;
  logic                       rst            = 1'b1;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic [1:0]                 kind           = KIND_FIND;
  logic [15:0]                event_id       = '0;
  logic [7:0]                 event_priority = '0;
  logic [15:0]                event_time     = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic [1:0]                 status;
  logic [15:0]                out_id;
  logic [7:0]                 out_priority;
  logic [15:0]                out_time;
  logic [$clog2(DEPTH+1)-1:0] occupancy;

  int fail_count, owed_count, replies_checked, full_refusals, empty_refusals;
  int cycle_count = 0;
  int ready_hold  = 0;
  int ready_pick;
  int sent_kind [4] = '{0, 0, 0, 0};
  bit no_gaps = 1'b0;

  sorted_priority_event_queue_core #(.DEPTH(DEPTH)) dut (
    .clk, .rst, .in_valid, .in_ready, .kind, .event_id, .event_priority,
    .event_time, .out_valid, .out_ready, .status, .out_id, .out_priority,
    .out_time, .occupancy
  );

  sorted_priority_event_queue_checker #(.DEPTH(DEPTH)) u_checker (
    .clk, .rst, .in_valid, .in_ready, .kind, .event_id, .event_priority,
    .event_time, .out_valid, .out_ready, .status, .out_id, .out_priority,
    .out_time, .occupancy, .fail_count, .owed_count, .replies_checked,
    .full_refusals, .empty_refusals
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d replies owed", $time, owed_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 55) begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(1, 30);
      end else if (ready_pick < 90) begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(5, 20);
      end
    end else begin
      ready_hold--;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic [1:0] k, input logic [15:0] id,
                           input logic [7:0] pri, input logic [15:0] ts);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    event_id       <= id;
    event_priority <= pri;
    event_time     <= ts;
    do @(posedge clk); while (!in_ready);
    sent_kind[k]++;
  endtask

  task automatic random_item(input int mode);
    int          r;
    logic [1:0]  k;
    logic [15:0] id;
    logic [7:0]  pri;
    r = $urandom_range(0, 99);
    case (mode)
      0:       k = (r < 45) ? KIND_INSERT : (r < 75) ? KIND_APPEND :
                   (r < 88) ? KIND_POP : KIND_FIND;
      1:       k = (r < 12) ? KIND_INSERT : (r < 20) ? KIND_APPEND :
                   (r < 80) ? KIND_POP : KIND_FIND;
      default: k = (r < 25) ? KIND_INSERT : (r < 50) ? KIND_APPEND :
                   (r < 75) ? KIND_POP : KIND_FIND;
    endcase
    id  = ($urandom_range(0, 99) < 65) ? 16'($urandom_range(0, 15))
                                       : 16'($urandom_range(0, 65535));
    pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                      : 8'($urandom_range(0, 255));
    send_item(k, id, pri, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    int mode;
    int seg_left;
    seg_left = 0;
    mode     = 2;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_POP, 16'h1234, 8'h12, 16'h5678);
    send_item(KIND_FIND, 16'h0000, 8'h00, 16'h0000);
    send_item(KIND_INSERT, 16'h0000, 8'h00, 16'h0000);
    send_item(KIND_INSERT, 16'hffff, 8'hff, 16'hffff);
    send_item(KIND_INSERT, 16'h0001, 8'hff, 16'h0001);
    send_item(KIND_APPEND, 16'h0002, 8'hff, 16'h0002);
    send_item(KIND_FIND, 16'h0000, 8'h7f, 16'hffff);
    send_item(KIND_FIND, 16'h00aa, 8'h00, 16'h0000);
    send_item(KIND_POP, 16'h0000, 8'h00, 16'h0000);
    for (int i = 0; i < 13; i++) begin
      send_item((i % 3 == 2) ? KIND_APPEND : KIND_INSERT, 16'(16'h0100 + i),
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    end
    send_item(KIND_INSERT, 16'h0fff, 8'hff, 16'haaaa);
    send_item(KIND_APPEND, 16'h0ffe, 8'h00, 16'h5555);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(8, 48);
        no_gaps  = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      random_item(mode);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d inserts, %0d appends, %0d pops and %0d finds.",
             sent_kind[KIND_INSERT], sent_kind[KIND_APPEND], sent_kind[KIND_POP],
             sent_kind[KIND_FIND]);
    $display("Checked %0d replies, %0d refused as full and %0d as empty.",
             replies_checked, full_refusals, empty_refusals);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
